// ----- src/datetime_add_sub_seconds_assert.svh -----
// assertion macros for the date/time shifter
`ifndef DATETIME_ADD_SUB_SECONDS_ASSERT_SVH
`define DATETIME_ADD_SUB_SECONDS_ASSERT_SVH
`ifndef SYNTHESIS
`define DTAS_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);
`define DTAS_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define DTAS_ASSERT_NOW(lbl, ante, cons, msg)
`define DTAS_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

// ----- src/dtas_pkg.sv -----
package dtas_pkg;

	localparam logic [16:0] SEC_DAY = 17'd86400;
	localparam int DIV_STEPS = 2;
	// ceil(2^35 / 675), exact quotient for 25-bit dividends
	localparam logic [25:0] DAY_RECIP = 26'd50903317;
	localparam int SEARCH_BITS = 14;
	localparam logic [23:0] Z_MIN = 24'd306;
	localparam logic [23:0] Z_MAX = 24'd3652364;
	localparam logic [13:0] YEAR_MAX = 14'd9999;
	localparam logic [13:0] YEAR_OVF = 14'd10000;
	localparam logic [2:0] WD_EDGE = 3'd6;

	typedef enum logic [2:0] {
		ST_OK, ST_TIME_BAD, ST_DATE_BAD, ST_OVER, ST_UNDER
	} status_t;

	typedef enum logic [3:0] {
		OP_NONE, OP_LATCH, OP_PREP, OP_DIV, OP_CALC, OP_HMS1, OP_HMS2,
		OP_HMS3, OP_HMS4, OP_SEARCH, OP_MONTH, OP_LOAD
	} op_t;

	typedef enum logic [3:0] {
		S_IDLE, S_PREP, S_DIV, S_CALC, S_HMS1, S_HMS2, S_HMS3, S_HMS4,
		S_SEARCH, S_MONTH, S_FIN
	} state_t;

	typedef struct packed {
		op_t        op;
		logic [4:0] idx;
	} cmd_t;

	typedef struct packed {
		logic time_bad;
		logic date_bad;
		logic out_range;
	} sts_t;

	// first day of each month counted from march
	function automatic logic [8:0] month_start(logic [3:0] mp);
		case (mp)
			4'd0:    month_start = 9'd0;
			4'd1:    month_start = 9'd31;
			4'd2:    month_start = 9'd61;
			4'd3:    month_start = 9'd92;
			4'd4:    month_start = 9'd122;
			4'd5:    month_start = 9'd153;
			4'd6:    month_start = 9'd184;
			4'd7:    month_start = 9'd214;
			4'd8:    month_start = 9'd245;
			4'd9:    month_start = 9'd275;
			4'd10:   month_start = 9'd306;
			4'd11:   month_start = 9'd337;
			default: month_start = 9'd0;
		endcase
	endfunction

	function automatic logic [4:0] month_len(logic [3:0] m, logic leap);
		case (m)
			4'd2:                      month_len = leap ? 5'd29 : 5'd28;
			4'd4, 4'd6, 4'd9, 4'd11:   month_len = 5'd30;
			default:                   month_len = 5'd31;
		endcase
	endfunction

	// exact for y below 18720
	function automatic logic [7:0] div100(logic [13:0] y);
		logic [23:0] p;
		p = 24'(y[13:2]) * 24'd2622;
		div100 = p[23:16];
	endfunction

	// days from march 1 of year 0 to march 1 of year y, q is y/100
	function automatic logic [23:0] year_base(logic [13:0] y, logic [7:0] q);
		year_base = 24'(y) * 24'd365 + 24'(y[13:2]) - 24'(q) + 24'(q[7:2]);
	endfunction

	// 8 is 1 mod 7, so fold octal digits
	function automatic logic [2:0] mod7(logic [23:0] z);
		logic [5:0] s1;
		logic [3:0] s2;
		logic [3:0] s3;
		s1 = '0;
		for (int i = 0; i < 8; i++) s1 = s1 + 6'(z[3*i +: 3]);
		s2 = 4'(s1[5:3]) + 4'(s1[2:0]);
		s3 = 4'(s2[3]) + 4'(s2[2:0]);
		mod7 = (s3 == 4'd7) ? 3'd0 : s3[2:0];
	endfunction

endpackage

// ----- src/datetime_add_sub_seconds.sv -----
// Gregorian date/time shifter, years 1 to 9999.
// Input channel (in_valid/in_ready): one beat carries a date, a time of day,
// an unsigned offset in seconds and kind (0 add, 1 subtract).
// Output channel (out_valid/out_ready): one beat per input beat with the
// shifted date and time, the weekday (0 Sunday) and a status code.
// Steps: latch and prepare, split the offset into days and seconds by a
// reciprocal, combine day number and time of day, form hours, minutes and
// seconds, find the year by a bit-by-bit search, then month and day, and load
// the result; a bad time goes to the load after the combine step, a bad date
// or out of range after the time steps. Only one item is in flight at a time.
// A finished result sits in the output register, so the next input beat is
// taken while the receiver stalls; a second result then waits until the
// first is taken.
// Reset clears the controller and drops out_valid; nothing else needs it.
`include "datetime_add_sub_seconds_assert.svh"
module datetime_add_sub_seconds (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        kind,
	input  logic [13:0] year_in,
	input  logic [3:0]  month_in,
	input  logic [4:0]  day_in,
	input  logic [4:0]  hour_in,
	input  logic [5:0]  minute_in,
	input  logic [5:0]  second_in,
	input  logic [31:0] offset_seconds,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [13:0] year_out,
	output logic [3:0]  month_out,
	output logic [4:0]  day_out,
	output logic [4:0]  hour_out,
	output logic [5:0]  minute_out,
	output logic [5:0]  second_out,
	output logic [2:0]  weekday,
	output logic [2:0]  status
);
	import dtas_pkg::*;

	cmd_t cmd;
	sts_t sts;
	logic ok_shape;

	dtas_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	dtas_dp u_dp (
		.clk            (clk),
		.cmd            (cmd),
		.kind           (kind),
		.year_in        (year_in),
		.month_in       (month_in),
		.day_in         (day_in),
		.hour_in        (hour_in),
		.minute_in      (minute_in),
		.second_in      (second_in),
		.offset_seconds (offset_seconds),
		.year_out       (year_out),
		.month_out      (month_out),
		.day_out        (day_out),
		.hour_out       (hour_out),
		.minute_out     (minute_out),
		.second_out     (second_out),
		.weekday        (weekday),
		.status         (status),
		.sts            (sts)
	);

	assign ok_shape = month_out >= 4'd1 && month_out <= 4'd12 && day_out >= 5'd1 &&
		hour_out < 5'd24 && weekday < 3'd7;

	`DTAS_ASSERT_NEXT(a_busy_after_beat, in_valid && in_ready, !in_ready, "ready after accept")
	`DTAS_ASSERT_NOW(a_load_idle, cmd.op == OP_LOAD, !out_valid || out_ready, "result overwritten")
	`DTAS_ASSERT_NOW(a_ok_fields, out_valid && status == ST_OK, ok_shape, "bad ok result")

endmodule

// ----- src/dtas_ctrl.sv -----
module dtas_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	output logic          out_valid,
	input  logic          out_ready,
	input  dtas_pkg::sts_t sts,
	output dtas_pkg::cmd_t cmd
);
	import dtas_pkg::*;

	state_t     state_q, state_d;
	logic [4:0] cnt_q, cnt_d;
	logic       out_valid_q, out_valid_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			cnt_q       <= cnt_d;
			out_valid_q <= out_valid_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		cnt_d    = cnt_q;
		in_ready = 1'b0;
		cmd.op   = OP_NONE;
		cmd.idx  = cnt_q;
		unique case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.op  = OP_LATCH;
					state_d = S_PREP;
				end
			end
			S_PREP: begin
				cmd.op  = OP_PREP;
				cnt_d   = 5'(DIV_STEPS - 1);
				state_d = S_DIV;
			end
			S_DIV: begin
				cmd.op = OP_DIV;
				if (cnt_q == '0) state_d = S_CALC;
				else cnt_d = cnt_q - 5'd1;
			end
			S_CALC: begin
				cmd.op  = OP_CALC;
				state_d = sts.time_bad ? S_FIN : S_HMS1;
			end
			S_HMS1: begin
				cmd.op  = OP_HMS1;
				state_d = S_HMS2;
			end
			S_HMS2: begin
				cmd.op  = OP_HMS2;
				state_d = S_HMS3;
			end
			S_HMS3: begin
				cmd.op  = OP_HMS3;
				state_d = S_HMS4;
			end
			S_HMS4: begin
				cmd.op  = OP_HMS4;
				cnt_d   = 5'(SEARCH_BITS - 1);
				state_d = (sts.date_bad || sts.out_range) ? S_FIN : S_SEARCH;
			end
			S_SEARCH: begin
				cmd.op = OP_SEARCH;
				if (cnt_q == '0) state_d = S_MONTH;
				else cnt_d = cnt_q - 5'd1;
			end
			S_MONTH: begin
				cmd.op  = OP_MONTH;
				state_d = S_FIN;
			end
			S_FIN: begin
				if (!out_valid_q || out_ready) begin
					cmd.op  = OP_LOAD;
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
		if (cmd.op == OP_LOAD) out_valid_d = 1'b1;
		else out_valid_d = out_valid_q && !out_ready;
	end

	assign out_valid = out_valid_q;

endmodule

// ----- src/dtas_dp.sv -----
module dtas_dp (
	input  logic           clk,
	input  dtas_pkg::cmd_t cmd,
	input  logic           kind,
	input  logic [13:0]    year_in,
	input  logic [3:0]     month_in,
	input  logic [4:0]     day_in,
	input  logic [4:0]     hour_in,
	input  logic [5:0]     minute_in,
	input  logic [5:0]     second_in,
	input  logic [31:0]    offset_seconds,
	output logic [13:0]    year_out,
	output logic [3:0]     month_out,
	output logic [4:0]     day_out,
	output logic [4:0]     hour_out,
	output logic [5:0]     minute_out,
	output logic [5:0]     second_out,
	output logic [2:0]     weekday,
	output logic [2:0]     status,
	output dtas_pkg::sts_t sts
);
	import dtas_pkg::*;

	logic        kind_q;
	logic [13:0] y_q;
	logic [3:0]  m_q;
	logic [4:0]  d_q;
	logic [4:0]  hh_q;
	logic [5:0]  mi_q, ss_q;
	logic [31:0] off_q;
	logic [16:0] tod_q, rem_q, nt_q, days_q;
	logic [15:0] quo_q;
	logic [13:0] yy_q, ys_q;
	logic [7:0]  qyy_q, qy_q;
	logic [8:0]  doy_q;
	logic        dok_q, over_q, under_q;
	logic signed [24:0] z_q, zr_q;
	logic [4:0]  h_q;
	logic [11:0] r60_q;
	logic [5:0]  mn_q, sc_q;
	logic [23:0] st_q;
	logic [13:0] ry_q;
	logic [3:0]  rm_q;
	logic [4:0]  rd_q;

	// combinational helpers
	logic [3:0]  mp_in;
	logic [50:0] recip;
	logic [13:0] c100;
	logic        is_c, leap, dok;
	logic [17:0] sum, nt_d;
	logic        dinc;
	logic signed [24:0] zr_d;
	logic [24:0] ph;
	logic [19:0] pm;
	logic [13:0] cand;
	logic [23:0] cbase;
	logic [8:0]  doy;
	logic [3:0]  mp;
	logic [3:0]  mm;

	assign sts.time_bad  = (hh_q >= 5'd24) || (mi_q >= 6'd60) || (ss_q >= 6'd60);
	assign sts.date_bad  = !dok_q;
	assign sts.out_range = over_q || under_q;

	always_comb begin
		mp_in = (m_q > 4'd2) ? m_q - 4'd3 : m_q + 4'd9;
		// offset / 86400 is (offset >> 7) / 675
		recip = 51'(off_q[31:7]) * 51'(DAY_RECIP);
		c100  = 14'(qy_q) * 14'd100;
		is_c  = (y_q == c100);
		leap  = ((y_q[1:0] == 2'd0) && !is_c) || (is_c && (qy_q[1:0] == 2'd0));
		dok   = (y_q != '0) && (y_q <= YEAR_MAX) && (m_q != '0) && (m_q <= 4'd12) &&
			(d_q != '0) && (d_q <= month_len(m_q, leap));
		sum   = 18'(tod_q) + 18'(rem_q);
		dinc  = 1'b0;
		if (!kind_q) begin
			nt_d = sum;
			if (sum >= 18'(SEC_DAY)) begin
				nt_d = sum - 18'(SEC_DAY);
				dinc = 1'b1;
			end
		end else if (rem_q <= tod_q) begin
			nt_d = 18'(tod_q) - 18'(rem_q);
		end else begin
			nt_d = 18'(SEC_DAY) + 18'(tod_q) - 18'(rem_q);
			dinc = 1'b1;
		end
		zr_d  = kind_q ? z_q - $signed(25'(days_q)) : z_q + $signed(25'(days_q));
		ph    = 25'(nt_q[16:4]) * 25'd4661;
		pm    = 20'(r60_q[11:2]) * 20'd1093;
		cand  = ys_q | (14'd1 << cmd.idx[3:0]);
		cbase = year_base(cand, div100(cand));
		doy   = 9'(zr_q[23:0] - st_q);
		mp    = 4'd0;
		for (int i = 1; i < 12; i++) begin
			if (doy >= month_start(4'(i))) mp = 4'(i);
		end
		mm = (mp < 4'd10) ? mp + 4'd3 : mp - 4'd9;
	end

	always_ff @(posedge clk) begin
		case (cmd.op)
			OP_LATCH: begin
				kind_q <= kind;
				y_q    <= year_in;
				m_q    <= month_in;
				d_q    <= day_in;
				hh_q   <= hour_in;
				mi_q   <= minute_in;
				ss_q   <= second_in;
				off_q  <= offset_seconds;
			end
			OP_PREP: begin
				tod_q <= 17'(hh_q) * 17'd3600 + 17'(mi_q) * 17'd60 + 17'(ss_q);
				yy_q  <= (m_q <= 4'd2) ? y_q - 14'd1 : y_q;
				qyy_q <= div100((m_q <= 4'd2) ? y_q - 14'd1 : y_q);
				qy_q  <= div100(y_q);
				doy_q <= month_start(mp_in) + 9'(d_q) - 9'd1;
				rem_q <= '0;
				quo_q <= '0;
			end
			OP_DIV: begin
				// whole days first, then the seconds left over
				if (cmd.idx[0]) quo_q <= recip[50:35];
				else rem_q <= 17'(off_q - 32'(quo_q) * 32'd86400);
			end
			OP_CALC: begin
				dok_q  <= dok;
				nt_q   <= nt_d[16:0];
				days_q <= 17'(quo_q) + 17'(dinc);
				z_q    <= $signed(25'(year_base(yy_q, qyy_q)) + 25'(doy_q));
			end
			OP_HMS1: begin
				h_q     <= ph[24:20];
				zr_q    <= zr_d;
				over_q  <= zr_d > $signed(25'(Z_MAX));
				under_q <= zr_d < $signed(25'(Z_MIN));
			end
			OP_HMS2: r60_q <= 12'(nt_q - 17'(h_q) * 17'd3600);
			OP_HMS3: mn_q <= pm[19:14];
			OP_HMS4: begin
				sc_q <= 6'(r60_q - 12'(mn_q) * 12'd60);
				ys_q <= '0;
				st_q <= '0;
			end
			OP_SEARCH: begin
				if (cbase <= zr_q[23:0]) begin
					ys_q <= cand;
					st_q <= cbase;
				end
			end
			OP_MONTH: begin
				rd_q <= 5'(doy - month_start(mp) + 9'd1);
				rm_q <= mm;
				ry_q <= (mm <= 4'd2) ? ys_q + 14'd1 : ys_q;
			end
			OP_LOAD: begin
				if (sts.time_bad) begin
					{year_out, month_out, day_out} <= {y_q, m_q, d_q};
					{hour_out, minute_out, second_out} <= {hh_q, mi_q, ss_q};
					weekday <= dok_q ? mod7(z_q[23:0] + 24'd3) : 3'd0;
					status  <= ST_TIME_BAD;
				end else begin
					{hour_out, minute_out, second_out} <= {h_q, mn_q, sc_q};
					if (!dok_q) begin
						{year_out, month_out, day_out} <= {y_q, m_q, d_q};
						weekday <= 3'd0;
						status  <= ST_DATE_BAD;
					end else if (over_q) begin
						{year_out, month_out, day_out} <= {YEAR_OVF, 4'd1, 5'd1};
						weekday <= WD_EDGE;
						status  <= ST_OVER;
					end else if (under_q) begin
						{year_out, month_out, day_out} <= {14'd0, 4'd1, 5'd1};
						weekday <= WD_EDGE;
						status  <= ST_UNDER;
					end else begin
						{year_out, month_out, day_out} <= {ry_q, rm_q, rd_q};
						weekday <= mod7(zr_q[23:0] + 24'd3);
						status  <= ST_OK;
					end
				end
			end
			default: ;
		endcase
	end

endmodule

// ----- test/tb_datetime_add_sub_seconds.sv -----
module tb_datetime_add_sub_seconds;
	import dtas_pkg::*;

	localparam int N_RANDOM = 2000;
	localparam int WATCHDOG_LIMIT = 20000;
	localparam int TAIL_CYCLES = 200;

	typedef struct {
		logic        sub;
		logic [13:0] yr;
		logic [3:0]  mo;
		logic [4:0]  dy;
		logic [4:0]  hr;
		logic [5:0]  mn;
		logic [5:0]  sc;
		logic [31:0] off;
	} shift_req_t;

	typedef struct {
		logic [13:0] yr;
		logic [3:0]  mo;
		logic [4:0]  dy;
		logic [4:0]  hr;
		logic [5:0]  mn;
		logic [5:0]  sc;
		logic [2:0]  wd;
		status_t     st;
	} shifted_t;

	// directed row: has_exp marks rows with a typed-in result
	typedef struct {
		shift_req_t req;
		bit         has_exp;
		shifted_t   res;
	} dir_row_t;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_ready;
	logic        kind;
	logic [13:0] year_in;
	logic [3:0]  month_in;
	logic [4:0]  day_in;
	logic [4:0]  hour_in;
	logic [5:0]  minute_in;
	logic [5:0]  second_in;
	logic [31:0] offset_seconds;
	logic        out_valid;
	logic        out_ready;
	logic [13:0] year_out;
	logic [3:0]  month_out;
	logic [4:0]  day_out;
	logic [4:0]  hour_out;
	logic [5:0]  minute_out;
	logic [5:0]  second_out;
	logic [2:0]  weekday;
	logic [2:0]  status;

	shifted_t expected_q[$];
	int       n_errors;
	int       n_sent;
	int       n_checked;
	int       n_status[5];
	int       idle_cycles;
	bit       stim_done;
	bit       calm;
	bit       hold_rx;

	datetime_add_sub_seconds i_dut (.*);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	function automatic bit is_leap(int y);
		return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
	endfunction

	function automatic int days_in_month(int y, int m);
		int lens[13] = '{0, 31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};
		return lens[m] + ((m == 2 && is_leap(y)) ? 1 : 0);
	endfunction

	function automatic bit date_valid(int y, int m, int d);
		if (y == 0 || y > 9999 || m == 0 || m > 12 || d == 0)
			return 0;
		return d <= days_in_month(y, m);
	endfunction

	// day number with 0000-03-01 as day zero
	function automatic longint days_since_epoch(int y, int m, int d);
		int yy;
		int era;
		int yoe;
		int mp;
		int doy;
		yy = (m <= 2) ? y - 1 : y;
		era = yy / 400;
		yoe = yy - era * 400;
		mp = (m > 2) ? m - 3 : m + 9;
		doy = (153 * mp + 2) / 5 + d - 1;
		return longint'(era) * 146097 + yoe * 365 + yoe / 4 - yoe / 100 + doy;
	endfunction

	function automatic void date_of_count(longint z, output int y, output int m,
			output int d);
		int era;
		int doe;
		int yoe;
		int doy;
		int mp;
		era = int'(z / 146097);
		doe = int'(z - longint'(era) * 146097);
		yoe = (doe - doe / 1460 + doe / 36524 - doe / 146096) / 365;
		doy = doe - (365 * yoe + yoe / 4 - yoe / 100);
		mp = (5 * doy + 2) / 153;
		d = doy - (153 * mp + 2) / 5 + 1;
		m = (mp < 10) ? mp + 3 : mp - 9;
		y = yoe + era * 400 + ((m <= 2) ? 1 : 0);
	endfunction

	function automatic shifted_t shift_datetime(shift_req_t r);
		shifted_t o;
		bit       dok;
		longint   z;
		longint   days;
		int       tod;
		int       part;
		int       nt;
		int       y;
		int       m;
		int       d;
		dok = date_valid(r.yr, r.mo, r.dy);
		o.yr = r.yr; o.mo = r.mo; o.dy = r.dy;
		o.hr = r.hr; o.mn = r.mn; o.sc = r.sc;
		o.wd = '0; o.st = ST_OK;
		if (r.hr >= 24 || r.mn >= 60 || r.sc >= 60) begin
			if (dok)
				o.wd = 3'((days_since_epoch(r.yr, r.mo, r.dy) + 3) % 7);
			o.st = ST_TIME_BAD;
			return o;
		end
		tod = (int'(r.hr) * 60 + r.mn) * 60 + r.sc;
		part = int'(r.off % 86400);
		days = longint'(r.off / 86400);
		if (!r.sub) begin
			nt = tod + part;
			if (nt >= 86400) begin
				nt -= 86400;
				days++;
			end
		end else if (part <= tod) begin
			nt = tod - part;
		end else begin
			nt = 86400 + tod - part;
			days++;
		end
		o.hr = 5'(nt / 3600);
		o.mn = 6'((nt % 3600) / 60);
		o.sc = 6'(nt % 60);
		if (!dok) begin
			o.st = ST_DATE_BAD;
			return o;
		end
		z = days_since_epoch(r.yr, r.mo, r.dy);
		z = r.sub ? z - days : z + days;
		if (z > days_since_epoch(9999, 12, 31)) begin
			o.yr = 14'd10000; o.mo = 4'd1; o.dy = 5'd1; o.wd = 3'd6; o.st = ST_OVER;
		end else if (z < days_since_epoch(1, 1, 1)) begin
			o.yr = '0; o.mo = 4'd1; o.dy = 5'd1; o.wd = 3'd6; o.st = ST_UNDER;
		end else begin
			date_of_count(z, y, m, d);
			o.yr = 14'(y); o.mo = 4'(m); o.dy = 5'(d);
			o.wd = 3'((z + 3) % 7);
		end
		return o;
	endfunction

	task automatic report_mismatch(string what, longint got, longint want);
		$display("mismatch on result %0d: %s got %0d expected %0d",
			n_checked, what, got, want);
		n_errors++;
	endtask

	// typed-in row against the predictor, field by field
	task automatic check_row(int idx, shifted_t got, shifted_t want);
		string tag;
		tag = $sformatf("typed-in row %0d", idx);
		if (got.yr !== want.yr) report_mismatch({tag, " year"}, got.yr, want.yr);
		if (got.mo !== want.mo) report_mismatch({tag, " month"}, got.mo, want.mo);
		if (got.dy !== want.dy) report_mismatch({tag, " day"}, got.dy, want.dy);
		if (got.hr !== want.hr) report_mismatch({tag, " hour"}, got.hr, want.hr);
		if (got.mn !== want.mn) report_mismatch({tag, " minute"}, got.mn, want.mn);
		if (got.sc !== want.sc) report_mismatch({tag, " second"}, got.sc, want.sc);
		if (got.wd !== want.wd) report_mismatch({tag, " weekday"}, got.wd, want.wd);
		if (got.st !== want.st) report_mismatch({tag, " status"}, got.st, want.st);
	endtask

	function automatic shift_req_t mk_req(bit sub, int y, int mo, int d, int h,
			int mi, int s, longint off);
		shift_req_t r;
		r.sub = sub; r.yr = 14'(y); r.mo = 4'(mo); r.dy = 5'(d);
		r.hr = 5'(h); r.mn = 6'(mi); r.sc = 6'(s); r.off = 32'(off);
		return r;
	endfunction

	function automatic shifted_t mk_res(int y, int mo, int d, int h, int mi,
			int s, int wd, status_t st);
		shifted_t o;
		o.yr = 14'(y); o.mo = 4'(mo); o.dy = 5'(d); o.hr = 5'(h);
		o.mn = 6'(mi); o.sc = 6'(s); o.wd = 3'(wd); o.st = st;
		return o;
	endfunction

	function automatic shift_req_t random_req();
		shift_req_t r;
		int sel;
		int y;
		int mo;
		r.sub = 1'($urandom);
		sel = $urandom_range(0, 99);
		if (sel < 80) begin
			y = (sel < 8) ? (($urandom & 1) ? $urandom_range(1, 3) : $urandom_range(9997, 9999))
				: $urandom_range(1, 9999);
			mo = $urandom_range(1, 12);
			r.yr = 14'(y); r.mo = 4'(mo);
			r.dy = 5'($urandom_range(1, days_in_month(y, mo)));
			r.hr = 5'($urandom_range(0, 23));
			r.mn = 6'($urandom_range(0, 59));
			r.sc = 6'($urandom_range(0, 59));
		end else begin
			r.yr = 14'($urandom); r.mo = 4'($urandom); r.dy = 5'($urandom);
			r.hr = 5'($urandom); r.mn = 6'($urandom); r.sc = 6'($urandom);
			if (sel < 90) begin
				r.hr = 5'($urandom_range(0, 23));
				r.mn = 6'($urandom_range(0, 59));
				r.sc = 6'($urandom_range(0, 59));
			end
		end
		case ($urandom_range(0, 3))
			0: r.off = 32'($urandom_range(0, 200000));
			1: r.off = 32'($urandom_range(0, 86400 * 400));
			default: r.off = $urandom;
		endcase
		return r;
	endfunction

	// valid drops only ahead of an idle stretch
	task automatic send_beat(shift_req_t r);
		int gap;
		if (!calm && $urandom_range(0, 3) == 0) begin
			gap = $urandom_range(1, 13);
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		kind <= r.sub; year_in <= r.yr; month_in <= r.mo; day_in <= r.dy;
		hour_in <= r.hr; minute_in <= r.mn; second_in <= r.sc;
		offset_seconds <= r.off;
		do @(posedge clk); while (!in_ready);
		n_sent++;
	endtask

	// sender; predictions are queued on acceptance in the monitor below
	shift_req_t pending_q[$];
	initial begin
		dir_row_t rows[$];
		dir_row_t row;
		in_valid = 1'b0; kind = 1'b0; year_in = '0; month_in = '0; day_in = '0;
		hour_in = '0; minute_in = '0; second_in = '0; offset_seconds = '0;
		n_sent = 0; stim_done = 0; calm = 0;
		row.has_exp = 1;
		row.req = mk_req(0, 1, 1, 1, 0, 0, 0, 0);
		row.res = mk_res(1, 1, 1, 0, 0, 0, 1, ST_OK); rows.push_back(row);
		row.req = mk_req(1, 1, 1, 1, 0, 0, 0, 1);
		row.res = mk_res(0, 1, 1, 23, 59, 59, 6, ST_UNDER); rows.push_back(row);
		row.req = mk_req(0, 9999, 12, 31, 23, 59, 59, 1);
		row.res = mk_res(10000, 1, 1, 0, 0, 0, 6, ST_OVER); rows.push_back(row);
		row.req = mk_req(0, 2024, 5, 6, 24, 0, 0, 5);
		row.res = mk_res(2024, 5, 6, 24, 0, 0, 1, ST_TIME_BAD); rows.push_back(row);
		row.req = mk_req(1, 16383, 15, 31, 31, 63, 63, 32'hFFFFFFFF);
		row.res = mk_res(16383, 15, 31, 31, 63, 63, 0, ST_TIME_BAD); rows.push_back(row);
		row.req = mk_req(0, 0, 0, 0, 23, 59, 59, 1);
		row.res = mk_res(0, 0, 0, 0, 0, 0, 0, ST_DATE_BAD); rows.push_back(row);
		row.req = mk_req(1, 2023, 2, 29, 0, 0, 0, 1);
		row.res = mk_res(2023, 2, 29, 23, 59, 59, 0, ST_DATE_BAD); rows.push_back(row);
		row.has_exp = 0;
		rows.push_back('{mk_req(0, 2024, 2, 28, 23, 59, 59, 1), 0, row.res});
		rows.push_back('{mk_req(1, 2000, 3, 1, 0, 0, 0, 1), 0, row.res});
		rows.push_back('{mk_req(0, 1900, 2, 28, 12, 0, 0, 86400), 0, row.res});
		rows.push_back('{mk_req(0, 1, 1, 1, 0, 0, 0, 32'hFFFFFFFF), 0, row.res});
		rows.push_back('{mk_req(1, 9999, 12, 31, 23, 59, 59, 32'hFFFFFFFF), 0, row.res});
		rows.push_back('{mk_req(1, 2000, 1, 1, 0, 0, 0, 0), 0, row.res});
		rows.push_back('{mk_req(0, 9998, 12, 31, 0, 0, 0, 86400 * 365), 0, row.res});
		rows.push_back('{mk_req(1, 9999, 1, 1, 0, 0, 0, 86400), 0, row.res});
		rows.push_back('{mk_req(0, 2024, 4, 31, 10, 0, 0, 86399), 0, row.res});
		rows.push_back('{mk_req(1, 5000, 13, 1, 0, 0, 0, 86401), 0, row.res});
		rows.push_back('{mk_req(0, 10000, 1, 1, 0, 0, 0, 3), 0, row.res});
		rows.push_back('{mk_req(0, 2024, 1, 1, 23, 60, 0, 3), 0, row.res});
		rows.push_back('{mk_req(0, 2024, 1, 1, 23, 0, 60, 3), 0, row.res});
		@(posedge arst_n);
		@(posedge clk);
		foreach (rows[i]) begin
			if (rows[i].has_exp)
				check_row(i, shift_datetime(rows[i].req), rows[i].res);
			send_beat(rows[i].req);
		end
		for (int i = 0; i < N_RANDOM; i++) begin
			if (i == N_RANDOM - 150)
				calm = 1;
			send_beat(random_req());
		end
		in_valid <= 1'b0;
		stim_done = 1;
	end

	// predictor hook and output check
	always @(posedge clk) begin
		shift_req_t r;
		shifted_t   e;
		if (arst_n && in_valid && in_ready) begin
			r.sub = kind; r.yr = year_in; r.mo = month_in; r.dy = day_in;
			r.hr = hour_in; r.mn = minute_in; r.sc = second_in; r.off = offset_seconds;
			expected_q.push_back(shift_datetime(r));
		end
		if (arst_n && out_valid && out_ready) begin
			if (expected_q.size() == 0) begin
				$display("result beat with nothing expected");
				n_errors++;
			end else begin
				e = expected_q.pop_front();
				if (year_out !== e.yr) report_mismatch("year", year_out, e.yr);
				if (month_out !== e.mo) report_mismatch("month", month_out, e.mo);
				if (day_out !== e.dy) report_mismatch("day", day_out, e.dy);
				if (hour_out !== e.hr) report_mismatch("hour", hour_out, e.hr);
				if (minute_out !== e.mn) report_mismatch("minute", minute_out, e.mn);
				if (second_out !== e.sc) report_mismatch("second", second_out, e.sc);
				if (weekday !== e.wd) report_mismatch("weekday", weekday, e.wd);
				if (status !== e.st) report_mismatch("status", status, e.st);
				if (e.st <= ST_UNDER) n_status[e.st]++;
			end
			n_checked++;
		end
	end

	// receiver with random stalls and one long hold-off to back up the block
	initial begin
		int gap;
		out_ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (n_sent == 40 && !hold_rx) begin
				hold_rx = 1;
				out_ready <= 1'b0;
				repeat (400) @(posedge clk);
			end
			if (!calm && $urandom_range(0, 4) == 0) begin
				out_ready <= 1'b0;
				gap = $urandom_range(1, 13);
				repeat (gap) @(posedge clk);
			end
			out_ready <= 1'b1;
		end
	end

	// watchdog and end of run
	initial begin
		n_errors = 0; n_checked = 0; hold_rx = 0; idle_cycles = 0;
		foreach (n_status[i]) n_status[i] = 0;
		arst_n = 1'b0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		while (!(stim_done && expected_q.size() == 0)) begin
			@(posedge clk);
			if ((in_valid && in_ready) || (out_valid && out_ready))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("watchdog: no beat for %0d cycles", WATCHDOG_LIMIT);
				$display("Testbench completed WITH ERRORS");
				$finish;
			end
		end
		repeat (TAIL_CYCLES) @(posedge clk);
		if (expected_q.size() != 0)
			report_mismatch("results outstanding", expected_q.size(), 0);
		$display("%0d items shifted and checked: ok %0d, bad time %0d, bad date %0d,",
			n_checked, n_status[0], n_status[1], n_status[2]);
		$display("overflow %0d, underflow %0d", n_status[3], n_status[4]);
		if (n_errors == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

// ----- files.f -----
+incdir+src
src/dtas_pkg.sv
src/dtas_ctrl.sv
src/dtas_dp.sv
src/datetime_add_sub_seconds.sv
test/tb_datetime_add_sub_seconds.sv
